// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the decoder RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising clock edge outside reset.
`define DXT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define DXT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DXT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/dxt_pkg.sv -----
// Shared types, constants and helper functions for the DXT block decoder.
// Depends on nothing; used by every decoder module.
package dxt_pkg;

  // Block format codes held in the format register.
  localparam logic [1:0] FMT_DXT1 = 2'd0;
  localparam logic [1:0] FMT_DXT3 = 2'd1;
  localparam logic [1:0] FMT_DXT5 = 2'd2;

  // Register index of the format register, taken from paddr bit 2.
  localparam logic REG_BLOCK_FORMAT = 1'b0;

  // Selector code of the fourth palette entry.
  localparam logic [1:0] SEL_LAST = 2'd3;

  // Six-step alpha mode: these steps give fixed zero and full alpha.
  localparam logic [2:0] ASTEP_ZERO = 3'd5;
  localparam logic [2:0] ASTEP_FULL = 3'd6;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  // Reciprocal multipliers for truncating division by 3, 5 and 7.
  // Exact for dividends below 2048, which covers every sum formed here.
  localparam logic [9:0]  DIV3_MUL = 10'd683;   // x/3 = (x*683) >> 11
  localparam logic [10:0] DIV5_MUL = 11'd1639;  // x/5 = (x*1639) >> 13
  localparam logic [11:0] DIV7_MUL = 12'd2341;  // x/7 = (x*2341) >> 14

  // Decoded block, handed from the lane stage to the texel output stage.
  typedef struct packed {
    logic [3:0][23:0] pal;    // four RGB entries, red in bits 7:0
    logic [7:0][7:0]  acode;  // endpoint and interpolated alpha codes
    logic [31:0]      sel;    // 2-bit color selectors
    logic [63:0]      ah;     // alpha half: nibbles or 3-bit selectors
    logic [1:0]       fmt;
    logic             three;  // DXT1 three-color mode
  } blk_t;

  // Widen a 565 word to 8 bits per channel by bit replication.
  function automatic logic [23:0] expand565(input logic [15:0] w);
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
    r = w[15:11];
    g = w[10:5];
    b = w[4:0];
    return {b, b[4:2], g, g[5:4], r, r[4:2]};
  endfunction

  // Small weight times an 8-bit value, as a shift-and-add.
  function automatic logic [10:0] wmul(input logic [2:0] w, input logic [7:0] a);
    logic [10:0] s;
    s = '0;
    if (w[0]) s = s + {3'b000, a};
    if (w[1]) s = s + {2'b00, a, 1'b0};
    if (w[2]) s = s + {1'b0, a, 2'b00};
    return s;
  endfunction

endpackage

// ----- rtl/core/dxt_block_decoder.sv -----
// Top level of the DXT1/DXT3/DXT5 block decoder: input stage, lanes, emitter.
// Depends on dxt_pkg, dxt_color_lane, dxt_alpha_lane, dxt_texel_mux and
// assert_macros.svh.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+------------------------------
//   in       | sink      | in_valid_i / in_stall_o   | alpha_half_i, color_half_i
//   out      | source    | out_valid_o / out_stall_i | texel_color_o, texel_index_o,
//            |           |                           | last_texel_o
//   config   | sink      | APB (psel, penable, ...)  | block_format at address 0
//
// A block is sent as sixteen texels through the single texel output port.
// It passes the input stage, the emitter and the output register; the next block is
// accepted while the current one is emitted, so blocks follow without gaps.
// Reset clears the format register to DXT1 and empties every stage.
// A stall on the output holds the current texel and backs up into the input.
`include "assert_macros.svh"

module dxt_block_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] alpha_half_i,
  input  logic [63:0] color_half_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] texel_color_o,
  output logic [3:0]  texel_index_o,
  output logic        last_texel_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0]    fmt_q;
  logic          cfg_wr;
  logic          in_acc;
  logic          p_valid_q, p_valid_d;
  logic [63:0]   p_ah_q;
  logic [63:0]   p_ch_q;
  logic          e_valid_q, e_valid_d;
  logic [3:0]    e_cnt_q, e_cnt_d;
  dxt_pkg::blk_t e_blk_q;
  dxt_pkg::blk_t blk_d;
  logic          e_issue;
  logic          e_done;
  logic          e_load;
  logic          o_valid_q, o_valid_d;
  logic [31:0]   o_color_q;
  logic [3:0]    o_index_q;
  logic          o_last_q;
  logic [31:0]   texel_color;
  logic [15:0]   w0;
  logic [15:0]   w1;
  logic [23:0]   e0_rgb;
  logic [23:0]   e1_rgb;
  logic          three;
  logic [2:0][7:0] mid2;
  logic [2:0][7:0] mid3;
  logic [6:1][7:0] acode_mid;

  // Configuration register: written on the access phase of an APB transaction.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == dxt_pkg::REG_BLOCK_FORMAT) ? {30'd0, fmt_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= dxt_pkg::FMT_DXT1;
    end else if (cfg_wr && paddr[2] == dxt_pkg::REG_BLOCK_FORMAT) begin
      fmt_q <= pwdata[1:0];
    end
  end

  // Stage control: the emitter issues a texel whenever the output register frees up.
  assign e_issue    = e_valid_q && (!o_valid_q || !out_stall_i);
  assign e_done     = e_issue && (e_cnt_q == 4'hf);
  assign e_load     = p_valid_q && (!e_valid_q || e_done);
  assign in_stall_o = p_valid_q && !e_load;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    p_valid_d = p_valid_q;
    if (in_acc) begin
      p_valid_d = 1'b1;
    end else if (e_load) begin
      p_valid_d = 1'b0;
    end
  end

  always_comb begin
    e_valid_d = e_valid_q;
    e_cnt_d   = e_cnt_q;
    if (e_load) begin
      e_valid_d = 1'b1;
      e_cnt_d   = '0;
    end else if (e_done) begin
      e_valid_d = 1'b0;
      e_cnt_d   = '0;
    end else if (e_issue) begin
      e_cnt_d = e_cnt_q + 4'd1;
    end
  end

  always_comb begin
    o_valid_d = o_valid_q;
    if (e_issue) begin
      o_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      o_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
      e_cnt_q   <= '0;
      o_valid_q <= 1'b0;
    end else begin
      p_valid_q <= p_valid_d;
      e_valid_q <= e_valid_d;
      e_cnt_q   <= e_cnt_d;
      o_valid_q <= o_valid_d;
    end
  end

  // Input stage: holds one accepted transaction for the lanes.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p_ah_q <= alpha_half_i;
      p_ch_q <= color_half_i;
    end
  end

  // Endpoint expansion and mode decision.
  assign w0     = p_ch_q[15:0];
  assign w1     = p_ch_q[31:16];
  assign e0_rgb = dxt_pkg::expand565(w0);
  assign e1_rgb = dxt_pkg::expand565(w1);
  assign three  = (fmt_q == dxt_pkg::FMT_DXT1) && (w0 <= w1);

  // Color lanes, one per channel.
  for (genvar g = 0; g < 3; g++) begin : g_color
    dxt_color_lane u_lane (
      .e0_i    (e0_rgb[8*g +: 8]),
      .e1_i    (e1_rgb[8*g +: 8]),
      .three_i (three),
      .mid2_o  (mid2[g]),
      .mid3_o  (mid3[g])
    );
  end

  // Alpha lanes, one per interpolated step.
  for (genvar s = 1; s < 7; s++) begin : g_alpha
    dxt_alpha_lane u_lane (
      .a0_i   (p_ah_q[7:0]),
      .a1_i   (p_ah_q[15:8]),
      .step_i (3'(s)),
      .code_o (acode_mid[s])
    );
  end

  // Gather lane results into the decoded block.
  always_comb begin
    blk_d.pal[0]   = e0_rgb;
    blk_d.pal[1]   = e1_rgb;
    blk_d.pal[2]   = mid2;
    blk_d.pal[3]   = mid3;
    blk_d.acode[0] = p_ah_q[7:0];
    blk_d.acode[1] = p_ah_q[15:8];
    for (int s = 1; s < 7; s++) begin
      blk_d.acode[s+1] = acode_mid[s];
    end
    blk_d.sel   = p_ch_q[63:32];
    blk_d.ah    = p_ah_q;
    blk_d.fmt   = fmt_q;
    blk_d.three = three;
  end

  always_ff @(posedge clk_i) begin
    if (e_load) begin
      e_blk_q <= blk_d;
    end
  end

  // Merging stage and output register.
  dxt_texel_mux u_mux (
    .blk_i   (e_blk_q),
    .idx_i   (e_cnt_q),
    .color_o (texel_color)
  );

  always_ff @(posedge clk_i) begin
    if (e_issue) begin
      o_color_q <= texel_color;
      o_index_q <= e_cnt_q;
      o_last_q  <= (e_cnt_q == 4'hf);
    end
  end

  assign out_valid_o   = o_valid_q;
  assign texel_color_o = o_color_q;
  assign texel_index_o = o_index_q;
  assign last_texel_o  = o_last_q;

  // The emitter keeps its block until the sixteenth texel has been issued.
  `DXT_ASSERT_NXT(a_emit_hold, clk_i, rst_ni, e_issue && e_cnt_q != 4'hf, e_valid_q, "emitter dropped a block early")
  // A newly loaded block starts at the first texel.
  `DXT_ASSERT_NXT(a_load_start, clk_i, rst_ni, e_load, e_cnt_q == 4'h0, "block load did not restart the count")
  // The last marker only goes with the sixteenth texel position.
  `DXT_ASSERT_IMP(a_last_index, clk_i, rst_ni, out_valid_o && last_texel_o, texel_index_o == 4'hf, "last marker on wrong texel")
  // An accepted transaction lands in the input stage.
  `DXT_ASSERT_NXT(a_in_capture, clk_i, rst_ni, in_acc, p_valid_q, "accepted block lost")

endmodule

// ----- rtl/core/dxt_color_lane.sv -----
// One color channel lane: computes the two interpolated palette entries.
// Depends on dxt_pkg for the reciprocal constant.
module dxt_color_lane (
  input  logic [7:0] e0_i,
  input  logic [7:0] e1_i,
  input  logic       three_i,
  output logic [7:0] mid2_o,
  output logic [7:0] mid3_o
);

  logic [8:0]  sum_half;
  logic [9:0]  sum2;
  logic [9:0]  sum3;
  logic [19:0] prod2;
  logic [19:0] prod3;

  // Weighted sums of the two endpoints.
  assign sum_half = {1'b0, e0_i} + {1'b0, e1_i};
  assign sum2     = {1'b0, e0_i, 1'b0} + {2'b00, e1_i};
  assign sum3     = {2'b00, e0_i} + {1'b0, e1_i, 1'b0};

  // Division by three through the reciprocal multiplier.
  assign prod2 = 20'(sum2) * 20'(dxt_pkg::DIV3_MUL);
  assign prod3 = 20'(sum3) * 20'(dxt_pkg::DIV3_MUL);

  // Three-color mode uses the midpoint and black for the last entry.
  always_comb begin
    if (three_i) begin
      mid2_o = sum_half[8:1];
      mid3_o = '0;
    end else begin
      mid2_o = prod2[18:11];
      mid3_o = prod3[18:11];
    end
  end

endmodule

// ----- rtl/core/dxt_alpha_lane.sv -----
// One alpha lane: computes one interpolated DXT5 alpha code for a given step.
// Depends on dxt_pkg for the weighting function and reciprocal constants.
module dxt_alpha_lane (
  input  logic [7:0] a0_i,
  input  logic [7:0] a1_i,
  input  logic [2:0] step_i,
  output logic [7:0] code_o
);

  logic        eight;
  logic [2:0]  w0;
  logic [10:0] wsum;
  logic [22:0] prod7;
  logic [21:0] prod5;

  // Eight-step mode when the first endpoint is larger.
  assign eight = (a0_i > a1_i);
  assign w0    = eight ? (3'd7 - step_i) : (3'd5 - step_i);
  assign wsum  = dxt_pkg::wmul(w0, a0_i) + dxt_pkg::wmul(step_i, a1_i);

  // Division by seven or five through reciprocal multipliers.
  assign prod7 = 23'(wsum) * 23'(dxt_pkg::DIV7_MUL);
  assign prod5 = 22'(wsum) * 22'(dxt_pkg::DIV5_MUL);

  // In six-step mode the two top steps are fixed zero and full alpha.
  always_comb begin
    priority if (eight) begin
      code_o = prod7[21:14];
    end else if (step_i == dxt_pkg::ASTEP_ZERO) begin
      code_o = '0;
    end else if (step_i == dxt_pkg::ASTEP_FULL) begin
      code_o = dxt_pkg::ALPHA_OPAQUE;
    end else begin
      code_o = prod5[20:13];
    end
  end

endmodule

// ----- rtl/core/dxt_texel_mux.sv -----
// Merging stage: picks the color and alpha of one texel from the lane results.
// Depends on dxt_pkg for the block type and format codes.
module dxt_texel_mux (
  input  dxt_pkg::blk_t blk_i,
  input  logic [3:0]    idx_i,
  output logic [31:0]   color_o
);

  logic [1:0]  sel;
  logic [3:0]  nib;
  logic [5:0]  apos;
  logic [2:0]  asel;
  logic [23:0] rgb;
  logic [7:0]  alpha;

  // Selector fields of this texel.
  assign sel  = blk_i.sel[{idx_i, 1'b0} +: 2];
  assign nib  = blk_i.ah[{idx_i, 2'b00} +: 4];
  assign apos = 6'd16 + {1'b0, idx_i, 1'b0} + {2'b00, idx_i};
  assign asel = blk_i.ah[apos +: 3];
  assign rgb  = blk_i.pal[sel];

  // Alpha source depends on the block format.
  always_comb begin
    priority if (blk_i.fmt == dxt_pkg::FMT_DXT1) begin
      alpha = (blk_i.three && sel == dxt_pkg::SEL_LAST) ? 8'd0 : dxt_pkg::ALPHA_OPAQUE;
    end else if (blk_i.fmt == dxt_pkg::FMT_DXT3) begin
      alpha = {nib, nib};
    end else begin
      alpha = blk_i.acode[asel];
    end
  end

  assign color_o = {alpha, rgb};

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for dxt_block_decoder: directed blocks, then random phases.
// Depends on dxt_pkg for the format codes, the register index and the selector and alpha constants; needs only the RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RAND_PHASES = 10;
  localparam int unsigned PHASE_ITEMS = 25;
  localparam int unsigned SETTLE_CYCLES = 8;

  // Byte addresses: the register index sits in paddr bit 2.
  localparam logic [2:0] ADDR_FORMAT = {dxt_pkg::REG_BLOCK_FORMAT, 2'b00};
  localparam logic [2:0] ADDR_UNUSED = {~dxt_pkg::REG_BLOCK_FORMAT, 2'b00};

  // One texel the decoder is expected to emit.
  typedef struct packed {
    logic [31:0] color;
    logic [3:0]  index;
    logic        last;
  } texel_exp_t;

  // One row of the directed stimulus, with an optional register write before it.
  typedef struct {
    bit          cfg;
    logic [2:0]  addr;
    logic [31:0] wdata;
    logic [63:0] ah;
    logic [63:0] ch;
    bit          typed;
    logic [31:0] color;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [63:0] alpha_half_i;
  logic [63:0] color_half_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] texel_color_o;
  logic [3:0]  texel_index_o;
  logic        last_texel_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  texel_exp_t  texel_q[$];
  dir_row_t    dir_tab[$];
  logic [1:0]  format_model;
  int unsigned err_count;
  int unsigned cycle_cnt = 0;
  logic [1:0]  stall_mode = 2'd0;
  int unsigned burst_left;

  dxt_block_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .alpha_half_i  (alpha_half_i),
    .color_half_i  (color_half_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .texel_color_o (texel_color_o),
    .texel_index_o (texel_index_o),
    .last_texel_o  (last_texel_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Free-running clock, 10 ns period.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string msg);
    $display("mismatch @%0d: %s", cycle_cnt, msg);
    err_count++;
  endtask

  // Widen a 565 word to {blue, green, red}, eight bits each.
  function automatic logic [23:0] widen565(input logic [15:0] w);
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
    r = w[15:11];
    g = w[10:5];
    b = w[4:0];
    return {b, b[4:2], g, g[5:4], r, r[4:2]};
  endfunction

  // Predict the packed RGBA value of texel t of one block.
  function automatic logic [31:0] predict_texel(input logic [1:0] fmt, input logic [63:0] ah,
                                                input logic [63:0] ch, input int unsigned t);
    logic [15:0] w0;
    logic [15:0] w1;
    logic [23:0] e0;
    logic [23:0] e1;
    logic [23:0] rgb;
    logic [1:0]  sel;
    logic [2:0]  asel;
    logic [7:0]  alpha;
    logic        three;
    int unsigned c0;
    int unsigned c1;
    int unsigned v;
    int unsigned a0;
    int unsigned a1;
    int unsigned step;
    w0 = ch[15:0];
    w1 = ch[31:16];
    three = (fmt == dxt_pkg::FMT_DXT1) && (w0 <= w1);
    e0 = widen565(w0);
    e1 = widen565(w1);
    sel = ch[32 + 2 * t +: 2];
    // Color channels, one byte lane at a time.
    for (int k = 0; k < 3; k++) begin
      c0 = 32'(e0[8 * k +: 8]);
      c1 = 32'(e1[8 * k +: 8]);
      case (sel)
        2'd0:    v = c0;
        2'd1:    v = c1;
        2'd2:    v = three ? (c0 + c1) / 2 : (2 * c0 + c1) / 3;
        default: v = three ? 0 : (c0 + 2 * c1) / 3;
      endcase
      rgb[8 * k +: 8] = v[7:0];
    end
    // Alpha depends on the format; code 3 falls through to interpolated alpha.
    if (fmt == dxt_pkg::FMT_DXT1) begin
      alpha = (three && sel == dxt_pkg::SEL_LAST) ? 8'd0 : dxt_pkg::ALPHA_OPAQUE;
    end else if (fmt == dxt_pkg::FMT_DXT3) begin
      v = 32'(ah[4 * t +: 4]);
      v = v * 17;
      alpha = v[7:0];
    end else begin
      a0 = 32'(ah[7:0]);
      a1 = 32'(ah[15:8]);
      asel = ah[16 + 3 * t +: 3];
      step = 32'(asel);
      if (asel == 3'd0) v = a0;
      else if (asel == 3'd1) v = a1;
      else if (a0 > a1) v = ((8 - step) * a0 + (step - 1) * a1) / 7;
      else if (asel == dxt_pkg::ASTEP_ZERO + 3'd1) v = 0;
      else if (asel == dxt_pkg::ASTEP_FULL + 3'd1) v = 255;
      else v = ((6 - step) * a0 + (step - 1) * a1) / 5;
      alpha = v[7:0];
    end
    // Transparent black clears the whole word in three-color mode.
    if (three && sel == dxt_pkg::SEL_LAST) rgb = '0;
    return {alpha, rgb[23:16], rgb[15:8], rgb[7:0]};
  endfunction

  // Queue the sixteen texels of an accepted block.
  task automatic queue_block_texels(input logic [63:0] ah, input logic [63:0] ch,
                                    input bit typed, input logic [31:0] color);
    texel_exp_t e;
    for (int unsigned t = 0; t < 16; t++) begin
      e.color = typed ? color : predict_texel(format_model, ah, ch, t);
      e.index = t[3:0];
      e.last  = (t == 15);
      texel_q.push_back(e);
    end
  endtask

  // Offer one block and hold it until the decoder takes it; valid stays high.
  task automatic send_block(input logic [63:0] ah, input logic [63:0] ch,
                            input bit typed, input logic [31:0] color);
    in_valid_i   <= 1'b1;
    alpha_half_i <= ah;
    color_half_i <= ch;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    queue_block_texels(ah, ch, typed, color);
  endtask

  // Burst bookkeeping after each transaction: drop valid for a random gap at burst end.
  task automatic pace_sender();
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 8);
    end
  endtask

  // Stop sending and wait until every queued texel has been seen.
  task automatic drain_decoder();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (texel_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup cycle, access cycle until pready, then an idle cycle in which
  // the format register is read back after a write to its index.
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr[2] == dxt_pkg::REG_BLOCK_FORMAT) format_model = data[1:0];
    @(posedge clk_i);
    if (addr[2] == dxt_pkg::REG_BLOCK_FORMAT && prdata !== {30'd0, format_model})
      report_mismatch($sformatf("format readback %h, want %h", prdata, format_model));
  endtask

  // Random block content, biased toward the mode boundaries now and then.
  task automatic make_block(output logic [63:0] ah, output logic [63:0] ch);
    ah = {$urandom, $urandom};
    ch = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: ch[31:16] = ch[15:0];
      1: ah[15:8] = ah[7:0];
      2: ch[31:0] = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                     $urandom_range(0, 1) ? 16'hFFFF : 16'h0000};
      3: ah[15:0] = {$urandom_range(0, 1) ? 8'hFF : 8'h00, $urandom_range(0, 1) ? 8'hFF : 8'h00};
      default: ;
    endcase
  endtask

  // Directed rows: reset format, endpoint extremes, both DXT1 modes, every format.
  task automatic build_directed();
    dir_tab.push_back(dir_row_t'{1'b0, ADDR_FORMAT, 32'd0, 64'h0, 64'h0, 1'b1, 32'hFF00_0000});
    dir_tab.push_back(dir_row_t'{1'b0, ADDR_FORMAT, 32'd0, 64'h0, 64'hFFFF_FFFF_0000_0000,
                                 1'b1, 32'h0});
    dir_tab.push_back(dir_row_t'{1'b0, ADDR_FORMAT, 32'd0, 64'h0, 64'h0000_0000_0000_FFFF,
                                 1'b1, 32'hFFFF_FFFF});
    dir_tab.push_back(dir_row_t'{1'b0, ADDR_FORMAT, 32'd0, 64'h0, 64'h5555_5555_0000_FFFF,
                                 1'b1, 32'hFF00_0000});
    dir_tab.push_back(dir_row_t'{1'b0, ADDR_FORMAT, 32'd0, '1, '1, 1'b1, 32'h0});
    dir_tab.push_back(dir_row_t'{1'b0, ADDR_FORMAT, 32'd0, 64'h0, 64'hE4E4_E4E4_F800_001F,
                                 1'b0, 32'd0});
    dir_tab.push_back(dir_row_t'{1'b0, ADDR_FORMAT, 32'd0, 64'h0, 64'hE4E4_E4E4_001F_F800,
                                 1'b0, 32'd0});
    dir_tab.push_back(dir_row_t'{1'b0, ADDR_FORMAT, 32'd0, '1, 64'h1B1B_1B1B_7BEF_7BEF,
                                 1'b0, 32'd0});
    // Explicit alpha.
    dir_tab.push_back(dir_row_t'{1'b1, ADDR_FORMAT, 32'(dxt_pkg::FMT_DXT3), 64'h0, 64'h0,
                                 1'b1, 32'h0});
    dir_tab.push_back(dir_row_t'{1'b0, ADDR_FORMAT, 32'd0, '1, 64'h0000_0000_0000_FFFF,
                                 1'b1, 32'hFFFF_FFFF});
    dir_tab.push_back(dir_row_t'{1'b0, ADDR_FORMAT, 32'd0, 64'hFEDC_BA98_7654_3210,
                                 64'hE4E4_E4E4_001F_F800, 1'b0, 32'd0});
    // Interpolated alpha: both step modes and equal endpoints.
    dir_tab.push_back(dir_row_t'{1'b1, ADDR_FORMAT, 32'(dxt_pkg::FMT_DXT5), 64'h00FF, 64'h0,
                                 1'b1, 32'hFF00_0000});
    dir_tab.push_back(dir_row_t'{1'b0, ADDR_FORMAT, 32'd0, 64'hFFFF_FFFF_FFFF_0000, 64'h0,
                                 1'b1, 32'hFF00_0000});
    dir_tab.push_back(dir_row_t'{1'b0, ADDR_FORMAT, 32'd0, 64'hFAC6_88FA_C688_20E0,
                                 64'hE4E4_E4E4_F800_001F, 1'b0, 32'd0});
    dir_tab.push_back(dir_row_t'{1'b0, ADDR_FORMAT, 32'd0, 64'hFAC6_88FA_C688_E020,
                                 64'hE4E4_E4E4_F800_001F, 1'b0, 32'd0});
    dir_tab.push_back(dir_row_t'{1'b0, ADDR_FORMAT, 32'd0, 64'hFAC6_88FA_C688_8080,
                                 64'h1B1B_1B1B_001F_F800, 1'b0, 32'd0});
    dir_tab.push_back(dir_row_t'{1'b0, ADDR_FORMAT, 32'd0, 64'hFAC6_88FA_C688_00FF, '1,
                                 1'b0, 32'd0});
    // A write to an unused index must leave the format alone.
    dir_tab.push_back(dir_row_t'{1'b1, ADDR_UNUSED, 32'd0, 64'h00FF, 64'hFFFF_FFFF_0000_0000,
                                 1'b1, 32'hFF00_0000});
    // The unused format code, reached with high junk bits, decodes as interpolated alpha.
    dir_tab.push_back(dir_row_t'{1'b1, ADDR_FORMAT, 32'hFFFF_FFFB, 64'h00FF,
                                 64'hFFFF_FFFF_0000_0000, 1'b1, 32'hFF00_0000});
    dir_tab.push_back(dir_row_t'{1'b0, ADDR_FORMAT, 32'd0, 64'hFAC6_88FA_C688_20E0,
                                 64'hE4E4_E4E4_F800_001F, 1'b0, 32'd0});
    dir_tab.push_back(dir_row_t'{1'b1, ADDR_FORMAT, 32'hFFFF_FFFC, 64'h0,
                                 64'hFFFF_FFFF_0000_0000, 1'b1, 32'h0});
  endtask

  // Output checker: compare every accepted texel with the oldest expectation.
  always @(posedge clk_i) begin
    texel_exp_t head;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (texel_q.size() == 0) begin
        report_mismatch($sformatf("unexpected texel color=%h index=%0d", texel_color_o,
                                  texel_index_o));
      end else begin
        head = texel_q.pop_front();
        if (texel_color_o !== head.color)
          report_mismatch($sformatf("texel %0d color %h, want %h", head.index, texel_color_o,
                                    head.color));
        if (texel_index_o !== head.index)
          report_mismatch($sformatf("texel index %0d, want %0d", texel_index_o, head.index));
        if (last_texel_o !== head.last)
          report_mismatch($sformatf("texel %0d last %b, want %b", head.index, last_texel_o,
                                    head.last));
      end
    end
  end

  // Receiver stall pattern: the mode is redrawn when cycle_cnt[5:0] is zero, mode 0 never stalls.
  always @(posedge clk_i) begin
    if (cycle_cnt[5:0] == 6'd0) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0:    out_stall_i <= 1'b0;
      2'd1:    out_stall_i <= ($urandom_range(0, 3) == 0);
      2'd2:    out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= cycle_cnt[1];
    endcase
  end

  // Cycle counter and run limit.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Main stimulus sequence.
  initial begin
    logic [63:0] ah;
    logic [63:0] ch;
    logic [1:0]  fmt;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    alpha_half_i <= '0;
    color_half_i <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    err_count    = 0;
    format_model = dxt_pkg::FMT_DXT1;
    burst_left   = 4;
    build_directed();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part.
    foreach (dir_tab[i]) begin
      if (dir_tab[i].cfg) begin
        drain_decoder();
        apb_write(dir_tab[i].addr, dir_tab[i].wdata);
      end
      send_block(dir_tab[i].ah, dir_tab[i].ch, dir_tab[i].typed, dir_tab[i].color);
      pace_sender();
    end

    // Random phases; the first four walk every format code, later ones pick at random.
    for (int unsigned p = 0; p < RAND_PHASES; p++) begin
      drain_decoder();
      fmt = (p < 4) ? 2'(p) : 2'($urandom_range(0, 3));
      if ($urandom_range(0, 2) == 0) apb_write(ADDR_UNUSED, $urandom);
      apb_write(ADDR_FORMAT, {$urandom_range(0, 1) ? 30'($urandom) : 30'd0, fmt});
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        make_block(ah, ch);
        send_block(ah, ch, 1'b0, 32'd0);
        pace_sender();
      end
    end

    drain_decoder();
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/dxt_pkg.sv
rtl/core/dxt_color_lane.sv
rtl/core/dxt_alpha_lane.sv
rtl/core/dxt_texel_mux.sv
rtl/core/dxt_block_decoder.sv
tb/tb_top.sv
